### design/rpb_pkg.sv
// Shared types, constants and fixed-point helpers for the RGBA pixel blend unit.
package rpb_pkg;

    localparam int QW = 17;
    localparam int NST = 22;
    localparam int DIV_STEPS = 17;
    localparam int DIV_FIRST = 4;
    localparam int DIV_LAST = DIV_FIRST + DIV_STEPS - 1;
    localparam int OUT_STAGE = NST - 1;
    localparam logic [QW-1:0] Q_ONE = 17'h10000;

    typedef logic [QW-1:0] q_t;
    typedef logic [NST-1:0] stage_vec_t;

    typedef enum logic [2:0] {
        MODE_NORMAL      = 3'd0,
        MODE_MULTIPLY    = 3'd1,
        MODE_ADDITIVE    = 3'd2,
        MODE_SUBTRACTIVE = 3'd3,
        MODE_OVERWRITE   = 3'd4
    } mode_t;

    function automatic q_t to_q(input logic [7:0] v);
        return {1'b0, v, v} + {16'd0, (v != 8'd0)};
    endfunction

    function automatic q_t qmul(input q_t a, input q_t b);
        logic [2*QW-1:0] p;
        p = a * b;
        return p[QW+15:16];
    endfunction

    function automatic logic [7:0] from_q(input q_t q);
        logic [QW+7:0] p;
        logic [QW+7:0] qc;
        qc = (q > Q_ONE) ? {8'd0, Q_ONE} : {8'd0, q};
        p = (qc << 8) - qc;
        return p[23:16];
    endfunction

endpackage

### design/rgba_pixel_blend_unit.sv
// RGBA pixel blend unit: three color lanes, shared alpha path and output merge.
// Takes one source/destination pixel pair per clock while the output is not stalled
// and returns one blended pixel for each accepted pair. Each color lane holds a 17-stage
// restoring divider that divides the composite by the output alpha. The pipeline stalls
// stage by stage, so a new word is accepted whenever any stage ahead has room, even
// while the output word waits to be taken.
module rgba_pixel_blend_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue, dst_alpha
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_red, out_green, out_blue, out_alpha
    output logic [31:0] m_tdata
);
    import rpb_pkg::*;

    mode_t mode_reg;
    stage_vec_t valid_reg;
    stage_vec_t ready;

    q_t s0_reg [4];
    q_t d0_reg [4];
    q_t dent1_reg, at1_reg, sa1_reg, da1_reg;
    q_t den2_reg;
    logic [QW:0] asum;

    logic byp_reg [OUT_STAGE];
    logic [31:0] pix_reg [OUT_STAGE];
    logic [7:0] alpha_reg [OUT_STAGE];
    logic byp_next;
    logic [31:0] pix_next;

    q_t quo [3];
    logic [31:0] out_reg;

    always_comb begin
        ready[OUT_STAGE] = !valid_reg[OUT_STAGE] || m_tready;
        for (int k = OUT_STAGE - 1; k >= 0; k--) begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end

    assign s_tready = ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NORMAL;
            valid_reg <= '0;
        end else begin
            if (cfg_wen) begin
                mode_reg <= mode_t'(cfg_wdata);
            end
            if (ready[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (ready[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_comb begin
        byp_next = 1'b1;
        if (mode_reg == MODE_OVERWRITE) begin
            pix_next = s_tdata[31:0];
        end else if (s_tdata[31:24] == 8'd0) begin
            pix_next = s_tdata[63:32];
        end else begin
            pix_next = s_tdata[31:0];
            byp_next = (s_tdata[63:56] == 8'd0);
        end
    end

    always_ff @(posedge aclk) begin
        if (ready[0]) begin
            for (int i = 0; i < 4; i++) begin
                s0_reg[i] <= to_q(s_tdata[8*i +: 8]);
                d0_reg[i] <= to_q(s_tdata[32 + 8*i +: 8]);
            end
            byp_reg[0] <= byp_next;
            pix_reg[0] <= pix_next;
            alpha_reg[0] <= '0;
        end
        if (ready[1]) begin
            dent1_reg <= qmul(d0_reg[3], Q_ONE - s0_reg[3]);
            at1_reg <= qmul(Q_ONE - d0_reg[3], s0_reg[3]);
            sa1_reg <= s0_reg[3];
            da1_reg <= d0_reg[3];
        end
        if (ready[2]) begin
            den2_reg <= sa1_reg + dent1_reg;
        end
    end

    assign asum = {1'b0, da1_reg} + {1'b0, at1_reg};

    for (genvar k = 1; k < OUT_STAGE; k++) begin : g_carry
        always_ff @(posedge aclk) begin
            if (ready[k]) begin
                byp_reg[k] <= byp_reg[k-1];
                pix_reg[k] <= pix_reg[k-1];
                if (k == 2) begin
                    alpha_reg[k] <= from_q((asum > {1'b0, Q_ONE}) ? Q_ONE : asum[QW-1:0]);
                end else begin
                    alpha_reg[k] <= alpha_reg[k-1];
                end
            end
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_lane
        rpb_lane u_lane (
            .aclk     (aclk),
            .stage_en (ready),
            .mode     (mode_reg),
            .s_q      (s0_reg[c]),
            .d_q      (d0_reg[c]),
            .sa_q     (s0_reg[3]),
            .da_q     (d0_reg[3]),
            .den_q    (den2_reg),
            .quo      (quo[c])
        );
    end

    always_ff @(posedge aclk) begin
        if (ready[OUT_STAGE]) begin
            if (byp_reg[OUT_STAGE-1]) begin
                out_reg <= pix_reg[OUT_STAGE-1];
            end else begin
                out_reg <= {alpha_reg[OUT_STAGE-1], from_q(quo[2]), from_q(quo[1]),
                            from_q(quo[0])};
            end
        end
    end

    assign m_tvalid = valid_reg[OUT_STAGE];
    assign m_tdata = out_reg;

    a_full_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while output side can drain");

    a_empty_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> (valid_reg == '0))
        else $error("pipeline not empty after reset");

    a_out_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !valid_reg[OUT_STAGE-1]) |=> !m_tvalid)
        else $error("output word repeated");

endmodule

### design/rpb_lane.sv
// One color channel: mode adjustment, composite numerator and pipelined restoring divider.
module rpb_lane (
    input  logic              aclk,
    input  rpb_pkg::stage_vec_t stage_en,
    input  rpb_pkg::mode_t    mode,
    input  rpb_pkg::q_t       s_q,
    input  rpb_pkg::q_t       d_q,
    input  rpb_pkg::q_t       sa_q,
    input  rpb_pkg::q_t       da_q,
    input  rpb_pkg::q_t       den_q,
    output rpb_pkg::q_t       quo
);
    import rpb_pkg::*;

    q_t s1_reg, d1_reg, sa1_reg, dda1_reg, t1_reg;
    q_t c2_reg, dterm2_reg, sa2_reg;
    q_t c2_next, dterm2_next;
    logic [QW:0] num3_reg;
    q_t den3_reg;

    logic [QW:0] rem_reg [DIV_STEPS];
    q_t quo_reg [DIV_STEPS];
    q_t dden_reg [DIV_STEPS];

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            s1_reg <= s_q;
            d1_reg <= d_q;
            sa1_reg <= sa_q;
            dda1_reg <= qmul(d_q, da_q);
            t1_reg <= qmul(Q_ONE - d_q, Q_ONE - da_q);
        end
    end

    always_comb begin
        logic [QW:0] sum;
        sum = {1'b0, s1_reg} + {1'b0, dda1_reg};
        dterm2_next = qmul(dda1_reg, Q_ONE - sa1_reg);
        case (mode)
            MODE_MULTIPLY: c2_next = qmul(s1_reg, d1_reg + t1_reg);
            MODE_ADDITIVE: c2_next = (sum > {1'b0, Q_ONE}) ? Q_ONE : sum[QW-1:0];
            MODE_SUBTRACTIVE: c2_next = (s1_reg > dda1_reg) ? s1_reg - dda1_reg : '0;
            default: c2_next = s1_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            c2_reg <= c2_next;
            dterm2_reg <= dterm2_next;
            sa2_reg <= sa1_reg;
        end
        if (stage_en[3]) begin
            num3_reg <= {1'b0, qmul(c2_reg, sa2_reg)} + {1'b0, dterm2_reg};
            den3_reg <= den_q;
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        logic [QW:0] rem_in;
        q_t quo_in;
        q_t den_in;
        logic [QW:0] x;
        logic bit_q;

        if (j == 0) begin : g_first
            assign rem_in = num3_reg;
            assign quo_in = '0;
            assign den_in = den3_reg;
            assign x = rem_in;
        end else begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign quo_in = quo_reg[j-1];
            assign den_in = dden_reg[j-1];
            assign x = {rem_in[QW-1:0], 1'b0};
        end

        assign bit_q = (x >= {1'b0, den_in});

        always_ff @(posedge aclk) begin
            if (stage_en[DIV_FIRST + j]) begin
                rem_reg[j] <= bit_q ? x - {1'b0, den_in} : x;
                quo_reg[j] <= {quo_in[QW-2:0], bit_q};
                dden_reg[j] <= den_in;
            end
        end
    end

    assign quo = quo_reg[DIV_STEPS-1];

endmodule
